[rtl/wsd_pkg.sv]
// Package for the WebSocket frame deframer: field widths, header constants,
// parse phase encoding and the result record. No dependencies.
package wsd_pkg;

	localparam int BYTE_W   = 8;
	localparam int OPCODE_W = 4;
	localparam int LEN_W    = 63;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = 3;

	localparam int EXT16_BYTES = 2;
	localparam int EXT64_BYTES = 8;
	localparam int KEY_BYTES   = 4;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXT16   = 3'd2,
		PH_EXT64   = 3'd3,
		PH_KEY     = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	typedef struct packed {
		logic                is_header;
		logic                fin_flag;
		logic [OPCODE_W-1:0] frame_opcode;
		logic                masked_flag;
		logic [LEN_W-1:0]    frame_length;
		logic [BYTE_W-1:0]   payload_byte;
		logic                last;
	} result_t;

endpackage

[rtl/wsd_if.sv]
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Depends on wsd_pkg for the field widths.
interface wsd_in_if;
	logic                       valid;
	logic                       ready;
	logic [wsd_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
	logic                         valid;
	logic                         ready;
	logic                         is_header;
	logic                         fin_flag;
	logic [wsd_pkg::OPCODE_W-1:0] frame_opcode;
	logic                         masked_flag;
	logic [wsd_pkg::LEN_W-1:0]    frame_length;
	logic [wsd_pkg::BYTE_W-1:0]   payload_byte;
	logic                         last;

	modport source (output valid, output is_header, output fin_flag, output frame_opcode,
		output masked_flag, output frame_length, output payload_byte, output last,
		input ready);
	modport sink (input valid, input is_header, input fin_flag, input frame_opcode,
		input masked_flag, input frame_length, input payload_byte, input last,
		output ready);
endinterface

[rtl/websocket_frame_deframer_top.sv]
// Top level of the WebSocket frame deframer.
// Depends on wsd_pkg and the channel interfaces in wsd_if.sv.

// The deframer takes one frame byte per clock cycle while input ready is high
// and answers every item with at most one registered result: a header
// result once the length and masking key are complete, then one unmasked
// payload byte per payload item, the final one marked last. The parse state
// advances in the cycle an item is accepted, and results wait in a two-entry
// output stage, so a stalled output stops the input only after two results are
// held; input ready depends only on that stage, never on the parse phase.
module websocket_frame_deframer_top (
	input logic       clk,
	input logic       arst_n,
	wsd_in_if.sink    byte_ch,
	wsd_out_if.source result_ch
);
	import wsd_pkg::*;

	phase_t               ph_q, ph_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic [KEY_W-1:0]     key_q, key_d;
	logic [LEN_W-1:0]     pcnt_q, pcnt_d;
	logic                 fin_q, fin_d;
	logic [OPCODE_W-1:0]  op_q, op_d;
	logic                 msk_q, msk_d;

	logic                 accept;
	logic                 emit;
	logic                 len_done;
	logic                 hdr_emit;
	logic [LEN_W-1:0]     pcnt_inc;
	logic [BYTE_W-1:0]    key_byte;
	result_t              res;

	result_t              out_q, skid_q;
	logic                 out_valid_q, skid_valid_q;
	logic                 out_free;

	assign accept   = byte_ch.valid & byte_ch.ready;
	assign pcnt_inc = pcnt_q + LEN_W'(1);
	assign key_byte = BYTE_W'(key_q >> {~pcnt_q[1:0], 3'b000});

	always_comb begin
		ph_d     = ph_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		key_d    = key_q;
		pcnt_d   = pcnt_q;
		fin_d    = fin_q;
		op_d     = op_q;
		msk_d    = msk_q;
		emit     = 1'b0;
		len_done = 1'b0;
		hdr_emit = 1'b0;
		res      = '0;

		case (ph_q)
			PH_PAYLOAD: begin
				pcnt_d           = pcnt_inc;
				emit             = 1'b1;
				res.payload_byte = byte_ch.in_byte ^ key_byte;
				res.last         = (pcnt_inc == len_q);
				if (pcnt_inc == len_q) begin
					ph_d = PH_FIRST;
				end
			end
			PH_KEY: begin
				key_d = {key_q[KEY_W-BYTE_W-1:0], byte_ch.in_byte};
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(KEY_BYTES - 1)) begin
					hdr_emit = 1'b1;
				end
			end
			PH_EXT16, PH_EXT64: begin
				len_d = {len_q[LEN_W-BYTE_W-1:0], byte_ch.in_byte};
				cnt_d = cnt_q + CNT_W'(1);
				if ((ph_q == PH_EXT16 && cnt_q == CNT_W'(EXT16_BYTES - 1)) ||
				    (ph_q == PH_EXT64 && cnt_q == CNT_W'(EXT64_BYTES - 1))) begin
					len_done = 1'b1;
				end
			end
			PH_SECOND: begin
				msk_d = byte_ch.in_byte[7];
				len_d = '0;
				cnt_d = '0;
				if (byte_ch.in_byte[6:0] == LEN_EXT16) begin
					ph_d = PH_EXT16;
				end else if (byte_ch.in_byte[6:0] == LEN_EXT64) begin
					ph_d = PH_EXT64;
				end else begin
					len_d    = LEN_W'(byte_ch.in_byte[6:0]);
					len_done = 1'b1;
				end
			end
			default: begin
				fin_d  = byte_ch.in_byte[7];
				op_d   = byte_ch.in_byte[OPCODE_W-1:0];
				msk_d  = 1'b0;
				len_d  = '0;
				key_d  = '0;
				pcnt_d = '0;
				cnt_d  = '0;
				ph_d   = PH_SECOND;
			end
		endcase

		if (len_done) begin
			cnt_d = '0;
			if (msk_d) begin
				ph_d = PH_KEY;
			end else begin
				hdr_emit = 1'b1;
			end
		end

		if (hdr_emit) begin
			cnt_d         = '0;
			pcnt_d        = '0;
			emit          = 1'b1;
			res.is_header = 1'b1;
			res.last      = (len_d == '0);
			ph_d          = (len_d == '0) ? PH_FIRST : PH_PAYLOAD;
		end

		res.fin_flag     = fin_d;
		res.frame_opcode = op_d;
		res.masked_flag  = msk_d;
		res.frame_length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_FIRST;
			cnt_q  <= '0;
			len_q  <= '0;
			key_q  <= '0;
			pcnt_q <= '0;
			fin_q  <= 1'b0;
			op_q   <= '0;
			msk_q  <= 1'b0;
		end else if (accept) begin
			ph_q   <= ph_d;
			cnt_q  <= cnt_d;
			len_q  <= len_d;
			key_q  <= key_d;
			pcnt_q <= pcnt_d;
			fin_q  <= fin_d;
			op_q   <= op_d;
			msk_q  <= msk_d;
		end
	end

	assign byte_ch.ready = ~skid_valid_q;
	assign out_free      = ~out_valid_q | result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept & emit;
			end
		end else if (accept & emit) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else begin
				out_q <= res;
			end
		end else if (accept & emit) begin
			skid_q <= res;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.is_header    = out_q.is_header;
	assign result_ch.fin_flag     = out_q.fin_flag;
	assign result_ch.frame_opcode = out_q.frame_opcode;
	assign result_ch.masked_flag  = out_q.masked_flag;
	assign result_ch.frame_length = out_q.frame_length;
	assign result_ch.payload_byte = out_q.payload_byte;
	assign result_ch.last         = out_q.last;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer_top: drives frame bytes
// and checks every result against a directed value or a local frame parser.
// Depends on wsd_pkg, the channel interfaces in wsd_if.sv and the RTL top level.
module tb_top;
	import wsd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEMS_PER_PHASE = 150;

	typedef struct {
		logic [BYTE_W-1:0] data;
		bit                known;
		result_t           want;
	} frame_row_t;

	logic clk;
	logic arst_n;

	wsd_in_if byte_ch();
	wsd_out_if result_ch();

	websocket_frame_deframer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	frame_row_t directed_rows [29] = '{
		'{8'h81, 1'b0, '0},
		'{8'h00, 1'b1, '{1'b1, 1'b1, 4'h1, 1'b0, 63'd0, 8'h00, 1'b1}},
		'{8'h7F, 1'b0, '0},
		'{8'h81, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hA5, 1'b0, '0},
		'{8'h5A, 1'b0, '0},
		'{8'h3C, 1'b0, '0},
		'{8'h88, 1'b0, '0},
		'{8'h7E, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'h80, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h80, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'h12, 1'b0, '0},
		'{8'h34, 1'b0, '0},
		'{8'h56, 1'b0, '0},
		'{8'h78, 1'b1, '{1'b1, 1'b0, 4'h2, 1'b1, 63'd1, 8'h00, 1'b0}},
		'{8'hAB, 1'b1, '{1'b0, 1'b0, 4'h2, 1'b1, 63'd1, 8'hB9, 1'b1}}
	};

	frame_row_t byte_plan[$];
	result_t    pending_results[$];
	frame_row_t cur_row;
	bit         in_fire;
	int         src_idle;
	int         snk_idle;
	int         mismatch_count;
	int         cycle_count;

	phase_t            prs_phase;
	logic [3:0]        prs_index;
	logic [63:0]       prs_length;
	logic [KEY_W-1:0]  prs_key;
	logic [63:0]       prs_count;
	logic              prs_fin;
	logic [OPCODE_W-1:0] prs_opcode;
	logic              prs_masked;

	function automatic result_t frame_result(logic hdr, logic [BYTE_W-1:0] pbyte, logic lst);
		result_t r;
		r.is_header    = hdr;
		r.fin_flag     = prs_fin;
		r.frame_opcode = prs_opcode;
		r.masked_flag  = prs_masked;
		r.frame_length = prs_length[LEN_W-1:0];
		r.payload_byte = pbyte;
		r.last         = lst;
		return r;
	endfunction

	task automatic close_header(output result_t r);
		logic lst;
		lst = (prs_length == 64'd0);
		prs_count = '0;
		prs_index = '0;
		prs_phase = lst ? PH_FIRST : PH_PAYLOAD;
		r = frame_result(1'b1, 8'h00, lst);
	endtask

	// Once the length is known, a masked frame still has its key to read.
	task automatic finish_length(output bit got, output result_t r);
		prs_index = '0;
		got = 1'b0;
		r = '0;
		if (prs_masked) begin
			prs_phase = PH_KEY;
		end else begin
			close_header(r);
			got = 1'b1;
		end
	endtask

	task automatic deframe_byte(input logic [BYTE_W-1:0] b, output bit got, output result_t r);
		int k;
		int need;
		logic lst;
		got = 1'b0;
		r = '0;
		case (prs_phase)
			PH_PAYLOAD: begin
				k = int'(prs_count[1:0]);
				prs_count++;
				lst = (prs_count >= prs_length);
				if (lst) begin
					prs_phase = PH_FIRST;
				end
				r = frame_result(1'b0, b ^ prs_key[8*(3-k) +: 8], lst);
				got = 1'b1;
			end
			PH_KEY: begin
				prs_key = {prs_key[KEY_W-9:0], b};
				prs_index++;
				if (prs_index >= KEY_BYTES) begin
					close_header(r);
					got = 1'b1;
				end
			end
			PH_EXT16, PH_EXT64: begin
				need = (prs_phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;
				prs_length = {prs_length[55:0], b};
				prs_index++;
				if (prs_index >= need) begin
					prs_length[63] = 1'b0;
					finish_length(got, r);
				end
			end
			PH_SECOND: begin
				prs_masked = b[7];
				prs_length = '0;
				prs_index = '0;
				if (b[6:0] == LEN_EXT16) begin
					prs_phase = PH_EXT16;
				end else if (b[6:0] == LEN_EXT64) begin
					prs_phase = PH_EXT64;
				end else begin
					prs_length = 64'(b[6:0]);
					finish_length(got, r);
				end
			end
			default: begin
				prs_fin = b[7];
				prs_opcode = b[3:0];
				prs_masked = 1'b0;
				prs_length = '0;
				prs_key = '0;
				prs_count = '0;
				prs_index = '0;
				prs_phase = PH_SECOND;
			end
		endcase
	endtask

	task automatic add_byte(input logic [BYTE_W-1:0] b);
		frame_row_t row;
		row.data = b;
		row.known = 1'b0;
		row.want = '0;
		byte_plan.push_back(row);
	endtask

	// Mostly well-formed frames; a few are cut short so the next frame's bytes
	// land in the payload.
	task automatic add_random_frame();
		int pick;
		int plen;
		int sent;
		int n;
		logic masked;
		logic [63:0] ext;
		masked = 1'($urandom_range(1));
		pick = $urandom_range(99);
		add_byte(8'($urandom));
		if (pick < 70) begin
			plen = ($urandom_range(3) == 0) ? $urandom_range(125) : $urandom_range(8);
			add_byte({masked, 7'(plen)});
		end else if (pick < 85) begin
			plen = $urandom_range(12);
			add_byte({masked, LEN_EXT16});
			add_byte(8'(plen >> 8));
			add_byte(8'(plen));
		end else begin
			plen = $urandom_range(12);
			ext = 64'(plen);
			ext[63] = 1'($urandom_range(1));
			add_byte({masked, LEN_EXT64});
			for (n = 7; n >= 0; n--) begin
				add_byte(ext[8*n +: 8]);
			end
		end
		if (masked) begin
			repeat (KEY_BYTES) add_byte(8'($urandom));
		end
		sent = ($urandom_range(9) == 0) ? $urandom_range(plen) : plen;
		repeat (sent) add_byte(8'($urandom));
	endtask

	task automatic drive_rows();
		while (byte_plan.size() != 0 || byte_ch.valid) begin
			@(negedge clk);
			if (!byte_ch.valid || in_fire) begin
				if (byte_plan.size() != 0 && $urandom_range(99) >= src_idle) begin
					cur_row = byte_plan.pop_front();
					byte_ch.valid = 1'b1;
					byte_ch.in_byte = cur_row.data;
				end else begin
					byte_ch.valid = 1'b0;
				end
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] seen);
		if (want !== seen) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
			mismatch_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("websocket_frame_deframer_top verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_ch.ready <= arst_n && ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		bit got;
		result_t r;
		in_fire = arst_n && byte_ch.valid && byte_ch.ready;
		if (in_fire) begin
			deframe_byte(byte_ch.in_byte, got, r);
			if (cur_row.known) begin
				pending_results.push_back(cur_row.want);
			end else if (got) begin
				pending_results.push_back(r);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected, got header %0b length %0h byte %0h",
					$time, result_ch.is_header, result_ch.frame_length, result_ch.payload_byte);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("is_header", 64'(want.is_header), 64'(result_ch.is_header));
				check_field("fin_flag", 64'(want.fin_flag), 64'(result_ch.fin_flag));
				check_field("frame_opcode", 64'(want.frame_opcode), 64'(result_ch.frame_opcode));
				check_field("masked_flag", 64'(want.masked_flag), 64'(result_ch.masked_flag));
				check_field("frame_length", 64'(want.frame_length), 64'(result_ch.frame_length));
				check_field("payload_byte", 64'(want.payload_byte), 64'(result_ch.payload_byte));
				check_field("last", 64'(want.last), 64'(result_ch.last));
			end
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = '0;
		result_ch.ready = 1'b0;
		in_fire = 1'b0;
		cur_row = '{8'h00, 1'b0, '0};
		mismatch_count = 0;
		cycle_count = 0;
		src_idle = 17;
		snk_idle = 75;
		prs_phase = PH_FIRST;
		prs_index = '0;
		prs_length = '0;
		prs_key = '0;
		prs_count = '0;
		prs_fin = 1'b0;
		prs_opcode = '0;
		prs_masked = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (n = 0; n < $size(directed_rows); n++) begin
			byte_plan.push_back(directed_rows[n]);
		end
		while (byte_plan.size() < ITEMS_PER_PHASE) add_random_frame();
		drive_rows();

		wait_drained();
		src_idle = 75;
		snk_idle = 17;
		while (byte_plan.size() < ITEMS_PER_PHASE) add_random_frame();
		drive_rows();

		src_idle = 0;
		snk_idle = 0;
		while (byte_plan.size() < ITEMS_PER_PHASE) add_random_frame();
		// Largest length: all-ones 64-bit field with its top bit cleared.
		add_byte(8'h89);
		add_byte({1'b0, LEN_EXT64});
		repeat (EXT64_BYTES) add_byte(8'hFF);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h5A);
		drive_rows();

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("websocket_frame_deframer_top verification clean");
		end else begin
			$display("websocket_frame_deframer_top verification failed");
		end
		$finish;
	end
endmodule
